>>> rtl/spectral_max_magnitude_fusion_assert.svh
// Assertion macros for the spectral max magnitude fusion block.
`ifndef SPECTRAL_MAX_MAGNITUDE_FUSION_ASSERT_SVH
`define SPECTRAL_MAX_MAGNITUDE_FUSION_ASSERT_SVH

// check across reset itself
`define SMMF_ASSERT_RST(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) (cond) |=> (expr)) else $error(msg);

// check in the next cycle, off during reset
`define SMMF_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> rtl/smmf_pkg.sv
`default_nettype none
package smmf_pkg;
  localparam int DefMaxFrames = 32;
  localparam int DefCoefWidth = 24;
  localparam int OutWidth     = 24;
  localparam int NormFrac     = 16;
  localparam int QueueDepth   = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_OUT
  } back_state_t;
endpackage
`default_nettype wire

>>> rtl/smmf_front.sv
`default_nettype none
module smmf_front import smmf_pkg::*; #(
  parameter int MAX_FRAMES = DefMaxFrames,
  parameter int COEF_WIDTH = DefCoefWidth
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic signed [COEF_WIDTH-1:0]          coef_real,
  input  wire logic signed [COEF_WIDTH-1:0]          coef_imag,
  input  wire logic                                  last_frame,
  input  wire logic                                  push,
  output logic                                       full,
  output logic                                       job_push,
  output logic [2*COEF_WIDTH-2:0]                    job_peak,
  output logic signed [COEF_WIDTH+$clog2(MAX_FRAMES)-1:0] job_real,
  output logic signed [COEF_WIDTH+$clog2(MAX_FRAMES)-1:0] job_imag,
  input  wire logic                                  job_full
);
  localparam int SW = COEF_WIDTH + $clog2(MAX_FRAMES);
  localparam int PW = 2 * COEF_WIDTH - 1;

  logic [PW-1:0] peak, peak_next;
  logic signed [SW-1:0] run_re, run_re_next, run_im, run_im_next;
  logic signed [2*COEF_WIDTH-1:0] sq_re, sq_im;
  logic [2*COEF_WIDTH-1:0] mag;
  logic [PW-1:0] mag_sat;
  logic signed [SW:0] add_re, add_im;
  logic accept;

  assign accept = push & ~job_full;
  assign full   = job_full;

  assign sq_re   = coef_real * coef_real;
  assign sq_im   = coef_imag * coef_imag;
  assign mag     = $unsigned(sq_re) + $unsigned(sq_im);
  assign mag_sat = mag[2*COEF_WIDTH-1] ? {PW{1'b1}} : mag[PW-1:0];
  assign peak_next = (mag_sat > peak) ? mag_sat : peak;

  assign add_re = (SW+1)'(run_re) + (SW+1)'(coef_real);
  assign add_im = (SW+1)'(run_im) + (SW+1)'(coef_imag);

  always_comb begin
    if (add_re[SW] != add_re[SW-1]) begin
      run_re_next = add_re[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      run_re_next = add_re[SW-1:0];
    end
    if (add_im[SW] != add_im[SW-1]) begin
      run_im_next = add_im[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      run_im_next = add_im[SW-1:0];
    end
  end

  assign job_push = accept & last_frame;
  assign job_peak = peak_next;
  assign job_real = run_re_next;
  assign job_imag = run_im_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= '0;
      run_re <= '0;
      run_im <= '0;
    end else if (accept) begin
      if (last_frame) begin
        peak   <= '0;
        run_re <= '0;
        run_im <= '0;
      end else begin
        peak   <= peak_next;
        run_re <= run_re_next;
        run_im <= run_im_next;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/smmf_queue.sv
`default_nettype none
module smmf_queue import smmf_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  output logic                  valid,
  output logic [WIDTH-1:0]      dout,
  input  wire logic             pop
);
  localparam int AW = $clog2(QueueDepth);

  logic [WIDTH-1:0] mem [QueueDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic do_push, do_pop;

  assign full    = (count == (AW+1)'(QueueDepth));
  assign valid   = (count != '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/smmf_back.sv
`default_nettype none
module smmf_back import smmf_pkg::*; #(
  parameter int MAX_FRAMES = DefMaxFrames,
  parameter int COEF_WIDTH = DefCoefWidth
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  job_valid,
  input  wire logic [2*COEF_WIDTH-2:0]               job_peak,
  input  wire logic signed [COEF_WIDTH+$clog2(MAX_FRAMES)-1:0] job_real,
  input  wire logic signed [COEF_WIDTH+$clog2(MAX_FRAMES)-1:0] job_imag,
  output logic                                       job_take,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic signed [OutWidth-1:0]                 fused_real,
  output logic signed [OutWidth-1:0]                 fused_imag
);
  localparam int SW   = COEF_WIDTH + $clog2(MAX_FRAMES);
  localparam int PW   = 2 * COEF_WIDTH - 1;
  localparam int SQW  = 2 * SW;
  localparam int NW   = PW + 2 * NormFrac;
  localparam int RW   = (NW + 1) / 2;
  localparam int H    = (RW + 1) / 2;
  localparam int MBW  = (SW > H) ? SW : H;
  localparam int PRW  = SW + MBW;
  localparam int AW0  = (SQW > SW + 2 * H) ? SQW : SW + 2 * H;
  localparam int AW   = (AW0 > NormFrac + OutWidth) ? AW0 : NormFrac + OutWidth;
  localparam int CNTW = $clog2(NW + 1);
  localparam int RRW  = RW + 3;
  localparam int OW   = OutWidth;

  back_state_t state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;

  logic [PW-1:0] peak;
  logic signed [SW-1:0] s_re, s_im;
  logic [SW-1:0] mag_re, mag_im;
  logic [SQW-1:0] sq;
  logic [SQW-1:0] rem;
  logic [SQW:0] rem_t;
  logic div_ge;
  logic [NW-1:0] dq, dq_next;
  logic [2*RW-1:0] rad;
  logic [RRW-1:0] sr, rt, trial;
  logic sqrt_ge;
  logic [RW-1:0] root;
  logic [2*H-1:0] norm_ext;
  logic [SW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [PRW-1:0] prod;
  logic [AW-1:0] acc, sum_pp;
  logic [OW-1:0] res_re;
  logic out_valid, load_out;

  function automatic logic [OW-1:0] sat_out(input logic [AW-1:0] p, input logic neg);
    logic [AW-1:0] v;
    logic big;
    v   = p >> NormFrac;
    big = |(v >> (OW - 1));
    if (neg) begin
      sat_out = big ? {1'b1, {(OW-1){1'b0}}} : OW'(-v[OW-1:0]);
    end else begin
      sat_out = big ? {1'b0, {(OW-1){1'b1}}} : v[OW-1:0];
    end
  endfunction

  assign mag_re   = s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
  assign mag_im   = s_im[SW-1] ? SW'(-s_im) : SW'(s_im);
  assign norm_ext = (2*H)'(root);

  assign rem_t   = {rem, dq[NW-1]};
  assign div_ge  = (rem_t >= {1'b0, sq});
  assign dq_next = {dq[NW-2:0], div_ge};

  assign rt      = {sr[RRW-3:0], rad[2*RW-1 -: 2]};
  assign trial   = RRW'({root, 2'b01});
  assign sqrt_ge = (rt >= trial);

  always_comb begin
    mul_a = mag_re;
    mul_b = '0;
    if (state == ST_SQ) begin
      mul_a = (cnt == '0) ? mag_re : mag_im;
      mul_b = (cnt == '0) ? MBW'(mag_re) : MBW'(mag_im);
    end else if (state == ST_MUL) begin
      mul_a = cnt[1] ? mag_im : mag_re;
      mul_b = cnt[0] ? MBW'(norm_ext[2*H-1:H]) : MBW'(norm_ext[H-1:0]);
    end
  end

  assign sum_pp   = (state == ST_MUL) ? acc + (AW'(prod) << H) : acc + AW'(prod);
  assign load_out = (state == ST_OUT) & (~out_valid | pop);
  assign job_take = (state == ST_IDLE) & job_valid;
  assign empty    = ~out_valid;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (job_valid) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt == CNTW'(2)) begin
          state_next = ST_DIV;
          cnt_next   = '0;
        end
      end
      ST_DIV: begin
        if (cnt == CNTW'(NW - 1)) begin
          state_next = ST_SQRT;
          cnt_next   = '0;
        end
      end
      ST_SQRT: begin
        if (cnt == CNTW'(RW - 1)) begin
          state_next = ST_MUL;
          cnt_next   = '0;
        end
      end
      ST_MUL: begin
        if (cnt == CNTW'(4)) begin
          state_next = ST_OUT;
          cnt_next   = '0;
        end
      end
      ST_OUT: begin
        cnt_next = '0;
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PRW'(mul_a * mul_b);
    case (state)
      ST_IDLE: begin
        peak <= job_peak;
        s_re <= job_real;
        s_im <= job_imag;
      end
      ST_SQ: begin
        if (cnt == CNTW'(1)) begin
          acc <= AW'(prod);
        end else if (cnt == CNTW'(2)) begin
          sq  <= (sum_pp[SQW-1:0] == '0) ? SQW'(1) : sum_pp[SQW-1:0];
          dq  <= {peak, {(2*NormFrac){1'b0}}};
          rem <= '0;
        end
      end
      ST_DIV: begin
        rem <= div_ge ? SQW'(rem_t - {1'b0, sq}) : rem_t[SQW-1:0];
        dq  <= dq_next;
        if (cnt == CNTW'(NW - 1)) begin
          rad  <= (2*RW)'(dq_next);
          sr   <= '0;
          root <= '0;
        end
      end
      ST_SQRT: begin
        sr   <= sqrt_ge ? rt - trial : rt;
        root <= {root[RW-2:0], sqrt_ge};
        rad  <= rad << 2;
      end
      ST_MUL: begin
        if (cnt == CNTW'(1) || cnt == CNTW'(3)) begin
          acc <= AW'(prod);
        end else if (cnt == CNTW'(2)) begin
          res_re <= sat_out(sum_pp, s_re[SW-1]);
        end else if (cnt == CNTW'(4)) begin
          acc <= sum_pp;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      fused_real <= res_re;
      fused_imag <= sat_out(acc, s_im[SW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/spectral_max_magnitude_fusion.sv
`default_nettype none
// Fuses one frequency bin over a run of frames. Coefficients enter at one per
// cycle unless full: the front end tracks the peak squared magnitude and the
// complex sum. A request with last_frame set closes the bin and hands its
// totals through a two-entry queue to the back end. The back end squares the
// sum, does a bit-serial divide and a bit-serial square root, then scales
// and hands off the result; squaring and scaling share one multiplier. It
// takes the next bin only after the result is handed off. The front end only
// stalls while both queue entries hold closed bins.
module spectral_max_magnitude_fusion import smmf_pkg::*; #(
  parameter int MAX_FRAMES = DefMaxFrames,
  parameter int COEF_WIDTH = DefCoefWidth
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic signed [COEF_WIDTH-1:0] coef_real,
  input  wire logic signed [COEF_WIDTH-1:0] coef_imag,
  input  wire logic                         last_frame,
  input  wire logic                         push,
  output logic                              full,
  output logic signed [OutWidth-1:0]        fused_real,
  output logic signed [OutWidth-1:0]        fused_imag,
  output logic                              empty,
  input  wire logic                         pop
);
`include "spectral_max_magnitude_fusion_assert.svh"

  localparam int SW = COEF_WIDTH + $clog2(MAX_FRAMES);
  localparam int PW = 2 * COEF_WIDTH - 1;
  localparam int JW = PW + 2 * SW;

  logic job_push, job_full, q_valid, q_take;
  logic [PW-1:0] f_peak, b_peak;
  logic signed [SW-1:0] f_real, f_imag, b_real, b_imag;
  logic [JW-1:0] q_dout;

  smmf_front #(.MAX_FRAMES(MAX_FRAMES), .COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .coef_real (coef_real),
    .coef_imag (coef_imag),
    .last_frame(last_frame),
    .push      (push),
    .full      (full),
    .job_push  (job_push),
    .job_peak  (f_peak),
    .job_real  (f_real),
    .job_imag  (f_imag),
    .job_full  (job_full)
  );

  smmf_queue #(.WIDTH(JW)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .din  ({f_peak, f_real, f_imag}),
    .full (job_full),
    .valid(q_valid),
    .dout (q_dout),
    .pop  (q_take)
  );

  assign b_peak = q_dout[JW-1 -: PW];
  assign b_real = q_dout[2*SW-1 -: SW];
  assign b_imag = q_dout[SW-1:0];

  smmf_back #(.MAX_FRAMES(MAX_FRAMES), .COEF_WIDTH(COEF_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_peak  (b_peak),
    .job_real  (b_real),
    .job_imag  (b_imag),
    .job_take  (q_take),
    .empty     (empty),
    .pop       (pop),
    .fused_real(fused_real),
    .fused_imag(fused_imag)
  );

  `SMMF_ASSERT_RST(a_reset_clear, rst, empty && !full, "reset left a result or a full queue")
  `SMMF_ASSERT_NEXT(a_take_spacing, q_take, !q_take, "back end took two bins back to back")
  `SMMF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(fused_real) && $stable(fused_imag), "waiting result changed")
endmodule
`default_nettype wire

>>> tb/spectral_max_magnitude_fusion_test.sv
`default_nettype none
module spectral_max_magnitude_fusion_test;
  import smmf_pkg::*;

  localparam int CoefW   = DefCoefWidth;
  localparam int SumW    = CoefW + $clog2(DefMaxFrames);
  localparam int PeakW   = 2 * CoefW - 1;
  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic signed [CoefW-1:0] coef_real = '0;
  logic signed [CoefW-1:0] coef_imag = '0;
  logic last_frame = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic signed [OutWidth-1:0] fused_real;
  logic signed [OutWidth-1:0] fused_imag;

  logic [PeakW-1:0] bin_peak;
  longint bin_real_sum;
  longint bin_imag_sum;
  logic [OutWidth-1:0] fused_real_q[$];
  logic [OutWidth-1:0] fused_imag_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int frames_sent = 0;
  int bins_closed = 0;
  int results_seen = 0;

  spectral_max_magnitude_fusion u_dut (
    .clk(clk), .rst(rst),
    .coef_real(coef_real), .coef_imag(coef_imag), .last_frame(last_frame),
    .push(push), .full(full),
    .fused_real(fused_real), .fused_imag(fused_imag),
    .empty(empty), .pop(pop)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [OutWidth-1:0] got,
                                 logic [OutWidth-1:0] want);
    $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    mismatches++;
  endtask

  function automatic longint clamp_sum(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SumW - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [OutWidth-1:0] scale_sum(longint s, logic [63:0] norm);
    logic [127:0] mag;
    logic [127:0] p;
    longint v;
    longint lim;
    lim = longint'(1) <<< (OutWidth - 1);
    mag = s < 0 ? 128'(-s) : 128'(s);
    p = (mag * {64'd0, norm}) >> NormFrac;
    if (s < 0) v = p >= 128'(lim) ? -lim : -longint'(p);
    else v = p >= 128'(lim) ? lim - 1 : longint'(p);
    return v[OutWidth-1:0];
  endfunction

  task automatic fuse_frame(logic signed [CoefW-1:0] re, logic signed [CoefW-1:0] im,
                            logic last);
    longint r;
    longint i;
    logic [63:0] mag;
    logic [127:0] sq;
    logic [127:0] num;
    logic [63:0] norm;
    r = re;
    i = im;
    mag = 64'(r * r) + 64'(i * i);
    if (mag > 64'({PeakW{1'b1}})) mag = 64'({PeakW{1'b1}});
    if (mag > 64'(bin_peak)) bin_peak = mag[PeakW-1:0];
    bin_real_sum = clamp_sum(bin_real_sum + r);
    bin_imag_sum = clamp_sum(bin_imag_sum + i);
    frames_sent++;
    if (last) begin
      sq = 128'(bin_real_sum * bin_real_sum) + 128'(bin_imag_sum * bin_imag_sum);
      if (sq == '0) sq = 128'd1;
      num = {81'd0, bin_peak} << 32;
      norm = root_floor(num / sq);
      fused_real_q.push_back(scale_sum(bin_real_sum, norm));
      fused_imag_q.push_back(scale_sum(bin_imag_sum, norm));
      bin_peak = '0;
      bin_real_sum = 0;
      bin_imag_sum = 0;
      bins_closed++;
    end
  endtask

  task automatic send_frame(logic signed [CoefW-1:0] re, logic signed [CoefW-1:0] im,
                            logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    coef_real <= re;
    coef_imag <= im;
    last_frame <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    fuse_frame(re, im, last);
  endtask

  task automatic stop_push();
    push <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CoefW-1:0] pick_coef();
    case ($urandom_range(5))
      0: return CoefMax;
      1: return CoefMin;
      2: return '0;
      3: return CoefW'(int'($urandom_range(511)) - 256);
      default: return CoefW'($urandom);
    endcase
  endfunction

  task automatic send_bin(int frames);
    for (int k = 1; k <= frames; k++) send_frame(pick_coef(), pick_coef(), k == frames);
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (fused_real_q.size() == 0) begin
        report_mismatch("unexpected result", fused_real, '0);
      end else begin
        if (fused_real != fused_real_q[0])
          report_mismatch("fused_real", fused_real, fused_real_q[0]);
        if (fused_imag != fused_imag_q[0])
          report_mismatch("fused_imag", fused_imag, fused_imag_q[0]);
        void'(fused_real_q.pop_front());
        void'(fused_imag_q.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_corner_bins();
    send_frame(CoefMax, CoefMax, 1'b1);
    send_frame(CoefMin, CoefMin, 1'b1);
    send_frame(CoefMin, CoefMax, 1'b1);
    send_frame('0, '0, 1'b1);
    send_frame(CoefW'(1000), CoefW'(-2000), 1'b0);
    send_frame(CoefW'(-1000), CoefW'(2000), 1'b1);
    send_frame(CoefMax, '0, 1'b0);
    send_frame(CoefW'(-8388606), '0, 1'b1);
    send_frame(CoefMin, '0, 1'b0);
    send_frame(CoefMax, '0, 1'b0);
    send_frame('0, CoefW'(1), 1'b0);
    send_frame('0, CoefW'(-2), 1'b1);
    send_frame(CoefW'(3), CoefW'(4), 1'b0);
    send_frame(CoefW'(-5), CoefW'(12), 1'b0);
    send_frame(CoefW'(7), CoefW'(-1), 1'b1);
    send_frame(CoefW'(1), '0, 1'b1);
    send_frame(CoefW'(-1), CoefW'(-1), 1'b1);
  endtask

  task automatic test_random_bins(int items);
    int start;
    start = frames_sent;
    while (frames_sent - start < items) begin
      if ($urandom_range(19) == 0) send_bin($urandom_range(33, 40));
      else send_bin($urandom_range(1, 8));
    end
  endtask

  task automatic test_output_stall();
    hold_cycles = 600;
    for (int b = 0; b < 30; b++) send_bin(2);
  endtask

  initial begin
    bin_peak = '0;
    bin_real_sum = 0;
    bin_imag_sum = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_bins();
    send_idle_pct = 30;
    recv_idle_pct = 85;
    test_random_bins(550);
    send_idle_pct = 85;
    recv_idle_pct = 30;
    test_random_bins(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_bins(550);
    test_output_stall();
    stop_push();
    while (fused_real_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d frames in %0d bins, %0d results checked", frames_sent, bins_closed,
             results_seen);
    $display("covered extremes, zero sums, saturation, long runs and output stalls");
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
